@@ hdl/deq_pkg.sv @@
// Shared types and codes for the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int VALUE_W = 64;
  localparam int COUNT_W = 5;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REVERSE    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Physical moves applied to the cell row; at most one is set at a time.
  typedef struct packed {
    logic ins_first;
    logic ins_last;
    logic del_first;
    logic del_last;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/double_ended_queue.sv @@
// Top level of the bounded double-ended queue built on a row of shifting cells.
`timescale 1ns / 1ps
`default_nettype none

// Bounded double-ended queue of WORD_BITS-bit words, at most DEPTH held. Each item carries
// an operation (push front, push back, pop front, pop back, reverse) and returns one result:
// front and back words (0 when empty), the count and a status. Words live twice in a row of
// DEPTH cells: one chain packed toward the first slot, one toward the last, so both ends sit
// in fixed cells and every push or pop shifts one chain; a push also writes once into the other.
// Reversal only flips an orientation flag. One item is accepted per cycle unless a result waits
// untaken; the result register frees up when the result is taken, and a new item may enter in
// that same cycle. Pops and reverse on an empty queue and pushes on a full one report a status
// and change nothing. No clearing pass is needed after reset.
module double_ended_queue #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 64
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire  [2:0]                 in_op,
  input  wire  [deq_pkg::VALUE_W-1:0] in_value,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic [deq_pkg::VALUE_W-1:0] out_front_word,
  output logic [deq_pkg::VALUE_W-1:0] out_back_word,
  output logic [deq_pkg::COUNT_W-1:0] out_count,
  output logic [1:0]                 out_status
);
  import deq_pkg::*;

  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WORD_BITS-1:0] a_word [DEPTH];
  logic [WORD_BITS-1:0] b_word [DEPTH];
  logic [WORD_BITS-1:0] value_w;

  logic [CNT_BITS-1:0]  count_r, count_nxt;
  logic                 rev_r, rev_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              status_r, status_nxt;

  op_t                  op;
  logic                 accept;
  logic                 is_push, needs_words, at_first, full, empty;
  cell_ctrl_t           ctrl;
  logic [WORD_BITS-1:0] front_w, back_w;

  assign value_w  = in_value[WORD_BITS-1:0];
  assign op       = op_t'(in_op);
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CNT_BITS'(DEPTH));
  assign empty    = (count_r == '0);

  always_comb begin
    is_push     = op inside {OP_PUSH_FRONT, OP_PUSH_BACK};
    needs_words = op inside {OP_POP_FRONT, OP_POP_BACK, OP_REVERSE};
    // Front end is the first slot unless the queue is reversed.
    at_first    = (op inside {OP_PUSH_FRONT, OP_POP_FRONT}) != rev_r;
    ctrl        = '0;
    count_nxt   = count_r;
    rev_nxt     = rev_r;
    status_nxt  = status_r;
    if (accept) begin
      status_nxt = ST_DONE;
      if (is_push && full) begin
        status_nxt = ST_FULL;
      end else if (needs_words && empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        case (op)
          OP_PUSH_FRONT, OP_PUSH_BACK: begin
            ctrl.ins_first = at_first;
            ctrl.ins_last  = !at_first;
            count_nxt      = count_r + CNT_BITS'(1);
          end
          OP_POP_FRONT, OP_POP_BACK: begin
            ctrl.del_first = at_first;
            ctrl.del_last  = !at_first;
            count_nxt      = count_r - CNT_BITS'(1);
          end
          OP_REVERSE: begin
            rev_nxt = !rev_r;
          end
          default: begin
            // unused codes: report the current state only
          end
        endcase
      end
    end
    out_valid_nxt = accept ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [WORD_BITS-1:0] a_prev, a_next, b_prev, b_next;
      if (gi == 0) begin : g_head
        assign a_prev = value_w;
        assign b_prev = value_w;
      end else begin : g_mid
        assign a_prev = a_word[gi-1];
        assign b_prev = b_word[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_end
        assign a_next = a_word[gi];
        assign b_next = b_word[gi];
      end else begin : g_inner
        assign a_next = a_word[gi+1];
        assign b_next = b_word[gi+1];
      end
      deq_cell #(
        .WORD_BITS (WORD_BITS),
        .CNT_BITS  (CNT_BITS),
        .IDX       (gi)
      ) u_cell (
        .clk    (clk),
        .ctrl   (ctrl),
        .count  (count_r),
        .value  (value_w),
        .a_prev (a_prev),
        .a_next (a_next),
        .b_prev (b_prev),
        .b_next (b_next),
        .a_word (a_word[gi]),
        .b_word (b_word[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r <= status_nxt;
  end

  // Ends of the queue sit in cell zero of each chain.
  always_comb begin
    front_w = '0;
    back_w  = '0;
    if (!empty) begin
      front_w = rev_r ? b_word[0] : a_word[0];
      back_w  = rev_r ? a_word[0] : b_word[0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_front_word = VALUE_W'(front_w);
  assign out_back_word  = VALUE_W'(back_w);
  assign out_count      = COUNT_W'(count_r);
  assign out_status     = status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(DEPTH))
    else $error("count exceeds depth");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && full)
    |=> (status_r == ST_FULL && $stable(count_r)))
    else $error("push on full queue changed state");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (op == OP_POP_FRONT || op == OP_POP_BACK) && !empty)
    |=> (count_r == $past(count_r) - CNT_BITS'(1)))
    else $error("pop did not remove exactly one word");

  a_flag_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && op == OP_REVERSE) |=> $stable(rev_r))
    else $error("orientation changed without a reverse item");

endmodule

`default_nettype wire

@@ hdl/deq_cell.sv @@
// One cell of the queue row: a word of the front-packed chain and one of the back-packed chain.
`timescale 1ns / 1ps
`default_nettype none

module deq_cell #(
  parameter int WORD_BITS = 64,
  parameter int CNT_BITS  = 5,
  parameter int IDX       = 0
) (
  input  wire                       clk,
  input  deq_pkg::cell_ctrl_t       ctrl,
  input  wire  [CNT_BITS-1:0]       count,
  input  wire  [WORD_BITS-1:0]      value,
  input  wire  [WORD_BITS-1:0]      a_prev,
  input  wire  [WORD_BITS-1:0]      a_next,
  input  wire  [WORD_BITS-1:0]      b_prev,
  input  wire  [WORD_BITS-1:0]      b_next,
  output logic [WORD_BITS-1:0]      a_word,
  output logic [WORD_BITS-1:0]      b_word
);
  import deq_pkg::*;

  logic [WORD_BITS-1:0] a_r, a_nxt;
  logic [WORD_BITS-1:0] b_r, b_nxt;
  logic                 at_tail;

  // This cell is the first free slot past the held words.
  assign at_tail = (count == CNT_BITS'(IDX));

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    if (ctrl.ins_first) begin
      a_nxt = a_prev;
      if (at_tail) b_nxt = value;
    end else if (ctrl.ins_last) begin
      b_nxt = b_prev;
      if (at_tail) a_nxt = value;
    end else if (ctrl.del_first) begin
      a_nxt = a_next;
    end else if (ctrl.del_last) begin
      b_nxt = b_next;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign a_word = a_r;
  assign b_word = b_r;

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Testbench for the double-ended queue: a directed table, then random items checked on a mirror.
`timescale 1ns / 1ps

module tb;
  import deq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int WORD_BITS    = 64;
  localparam int RANDOM_ITEMS = 450;   // per idling phase
  localparam int HOLD_CYCLES  = 40;
  localparam int DRAIN_CYCLES = 8;
  localparam int QUIET_LIMIT  = 1000;

  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  localparam logic [63:0] ALL_ONES      = '1;

  typedef struct packed {
    logic [63:0] front;
    logic [63:0] back;
    logic [4:0]  count;
    status_t     status;
  } deq_view_t;

  // A typed note carries a result written out by hand; otherwise the mirror decides.
  typedef struct packed {
    bit        typed;
    deq_view_t want;
  } offer_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] value;
    logic [4:0]  reps;
    offer_t      note;
  } stim_row_t;

  localparam offer_t PREDICT = '0;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_op;
  logic [63:0] in_value;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_front_word;
  logic [63:0] out_back_word;
  logic [4:0]  out_count;
  logic [1:0]  out_status;

  double_ended_queue #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_front_word (out_front_word),
    .out_back_word  (out_back_word),
    .out_count      (out_count),
    .out_status     (out_status)
  );

  // Mirror of the queue state
  logic [63:0] mirror_words [DEPTH];
  logic [3:0]  mirror_head;
  logic [4:0]  mirror_count;
  logic        mirror_flipped;

  deq_view_t   awaited_views [$];
  offer_t      offered_notes [$];
  stim_row_t   directed_rows [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_req;

  int unsigned mismatches;
  int unsigned items_in;
  int unsigned results_seen;
  int unsigned full_refusals;
  int unsigned empty_refusals;
  int unsigned input_stalls;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic deq_view_t apply_to_mirror(logic [2:0] op, logic [63:0] value);
    deq_view_t view;
    logic      is_push;
    logic      at_first;
    logic [3:0] slot;
    is_push = (op == OP_PUSH_FRONT) || (op == OP_PUSH_BACK);
    view.status = ST_DONE;
    if (is_push && mirror_count == DEPTH) begin
      view.status = ST_FULL;
    end else if ((op == OP_POP_FRONT || op == OP_POP_BACK || op == OP_REVERSE) &&
                 mirror_count == 0) begin
      view.status = ST_EMPTY;
    end else if (op == OP_REVERSE) begin
      mirror_flipped = ~mirror_flipped;
    end else if (op <= OP_POP_BACK) begin
      // front maps to the physical first slot unless flipped
      at_first = ((op == OP_PUSH_FRONT) || (op == OP_POP_FRONT)) != mirror_flipped;
      if (is_push) begin
        if (at_first) begin
          mirror_head = mirror_head - 4'd1;
          mirror_words[mirror_head] = value;
        end else begin
          slot = mirror_head + mirror_count[3:0];
          mirror_words[slot] = value;
        end
        mirror_count = mirror_count + 5'd1;
      end else begin
        if (at_first) mirror_head = mirror_head + 4'd1;
        mirror_count = mirror_count - 5'd1;
      end
    end
    view.front = '0;
    view.back  = '0;
    if (mirror_count != 0) begin
      slot = mirror_head + mirror_count[3:0] - 4'd1;
      view.front = mirror_flipped ? mirror_words[slot] : mirror_words[mirror_head];
      view.back  = mirror_flipped ? mirror_words[mirror_head] : mirror_words[slot];
    end
    view.count = mirror_count;
    return view;
  endfunction

  function automatic offer_t typed_view(logic [63:0] front, logic [63:0] back,
                                        logic [4:0] count, status_t status);
    offer_t note;
    note.typed        = 1'b1;
    note.want.front   = front;
    note.want.back    = back;
    note.want.count   = count;
    note.want.status  = status;
    return note;
  endfunction

  task automatic add_row(logic [2:0] op, logic [63:0] value, logic [4:0] reps, offer_t note);
    stim_row_t row;
    row.op    = op;
    row.value = value;
    row.reps  = reps;
    row.note  = note;
    directed_rows.push_back(row);
  endtask

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %h, want %h", results_seen, name, got, want));
  endtask

  // Hold valid and payload until the item is taken
  task automatic send_item(logic [2:0] op, logic [63:0] value, offer_t note);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    offered_notes.push_back(note);
    in_valid <= 1'b1;
    in_op    <= op;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin : receiver
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : scoreboard
    offer_t    note;
    deq_view_t want;
    if (!rst_n) begin
      quiet_cycles = 0;
      mirror_head    = '0;
      mirror_count   = '0;
      mirror_flipped = 1'b0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (in_valid && !in_ready) input_stalls++;
      if (in_valid && in_ready) begin
        note = offered_notes.pop_front();
        want = apply_to_mirror(in_op, in_value);
        if (want.status == ST_FULL) full_refusals++;
        if (want.status == ST_EMPTY) empty_refusals++;
        awaited_views.push_back(note.typed ? note.want : want);
        items_in++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_views.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing awaited", results_seen));
        end else begin
          want = awaited_views.pop_front();
          check_field("front_word", out_front_word, want.front);
          check_field("back_word", out_back_word, want.back);
          check_field("count", 64'(out_count), 64'(want.count));
          check_field("status", 64'(out_status), 64'(want.status));
        end
      end
    end
  end

  initial begin : watchdog
    do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned idle_mix  [4];
    int unsigned stall_mix [4];
    int unsigned push_pct;
    int unsigned pick;
    int unsigned directed_count;
    logic [2:0]  op;
    logic [63:0] value;
    idle_mix  = '{0, 57, 0, 21};
    stall_mix = '{0, 0, 57, 21};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    mismatches     = 0;
    items_in       = 0;
    results_seen   = 0;
    full_refusals  = 0;
    empty_refusals = 0;
    input_stalls   = 0;
    quiet_cycles   = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_op    <= OP_PUSH_FRONT;
    in_value <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Empty queue refusals, spare codes, extremes, fill to full and drain
    add_row(OP_POP_FRONT, '0, 1, typed_view('0, '0, 0, ST_EMPTY));
    add_row(OP_POP_BACK, '0, 1, typed_view('0, '0, 0, ST_EMPTY));
    add_row(OP_REVERSE, '0, 1, typed_view('0, '0, 0, ST_EMPTY));
    add_row(OP_SPARE_FIRST, ALL_ONES, 1, typed_view('0, '0, 0, ST_DONE));
    add_row(OP_PUSH_BACK, '0, 1, typed_view('0, '0, 1, ST_DONE));
    add_row(OP_PUSH_FRONT, ALL_ONES, 1, typed_view(ALL_ONES, '0, 2, ST_DONE));
    add_row(OP_REVERSE, '0, 1, typed_view('0, ALL_ONES, 2, ST_DONE));
    add_row(OP_SPARE_LAST, '0, 1, typed_view('0, ALL_ONES, 2, ST_DONE));
    add_row(OP_POP_FRONT, '0, 1, PREDICT);
    add_row(OP_PUSH_FRONT, 64'h8000_0000_0000_0001, 1, PREDICT);
    add_row(OP_PUSH_BACK, 64'h0123_4567_89ab_cdef, 14, PREDICT);
    add_row(OP_PUSH_FRONT, ALL_ONES, 1, PREDICT);
    add_row(OP_PUSH_BACK, '0, 1, PREDICT);
    add_row(OP_REVERSE, '0, 1, PREDICT);
    add_row(OP_POP_BACK, '0, 3, PREDICT);
    add_row(OP_PUSH_BACK, 64'hfedc_ba98_7654_3210, 2, PREDICT);
    add_row(OP_POP_FRONT, '0, 15, PREDICT);
    add_row(OP_POP_BACK, '0, 1, typed_view('0, '0, 0, ST_EMPTY));
    add_row(OP_REVERSE, '0, 1, typed_view('0, '0, 0, ST_EMPTY));
    add_row(OP_PUSH_FRONT, 64'h5555_aaaa_5555_aaaa, 1, PREDICT);
    add_row(OP_POP_BACK, '0, 1, typed_view('0, '0, 0, ST_DONE));

    foreach (directed_rows[i])
      for (int k = 0; k < directed_rows[i].reps; k++)
        send_item(directed_rows[i].op, directed_rows[i].value + 64'(k), directed_rows[i].note);
    directed_count = items_in;

    for (int phase = 0; phase < 4; phase++) begin
      push_pct = 75;
      // long receiver hold-off while items keep coming
      if (stall_mix[phase] == 0 || phase == 2) hold_req = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        if (n % 60 == 0 && n != 0) push_pct = 100 - push_pct;
        send_idle_pct  = (n % 100 < 15) ? 0 : idle_mix[phase];
        recv_stall_pct = (n % 100 < 15) ? 0 : stall_mix[phase];
        pick = $urandom_range(0, 99);
        if (pick < 3) op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        else if (pick < 10) op = OP_REVERSE;
        else if ($urandom_range(0, 99) < push_pct)
          op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        else
          op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
        pick = $urandom_range(0, 99);
        if (pick < 10) value = '0;
        else if (pick < 20) value = ALL_ONES;
        else value = {$urandom, $urandom};
        send_item(op, value, PREDICT);
      end
    end
    in_valid <= 1'b0;
    recv_stall_pct = 0;

    while (awaited_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    // every accepted item must have produced its result by now
    if (awaited_views.size() != 0 || results_seen != items_in)
      report_mismatch($sformatf("%0d items accepted but %0d results seen",
                                items_in, results_seen));

    $display("Ran %0d items (%0d from the table) through four idling phases; %0d results compared.",
             items_in, directed_count, results_seen);
    $display("Pushes refused when full: %0d, pops or reversals refused when empty: %0d, %s %0d",
             full_refusals, empty_refusals, "cycles with the input held off:", input_stalls);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
